@@ rtl/sab_pkg.sv @@
// Package for the suffix automaton builder.
// Sequencer state codes and count constants; no dependencies.
`default_nettype none

package sab_pkg;

  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;
  localparam int SYM_W = 5;

  typedef enum logic [3:0] {
    ST_CLR_ROOT,
    ST_IDLE,
    ST_DECIDE,
    ST_CLR_CUR,
    ST_W1_RD,
    ST_W1_EV,
    ST_Q_EV,
    ST_COPY,
    ST_W2_EV,
    ST_Q_FIX,
    ST_FIN,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/suffix_automaton_builder_top.sv @@
// Suffix automaton builder top level: sequencer plus state and transition RAMs.
// Uses sab_pkg, sab_ram, sab_seq.
// From acceptance to the done strobe: decide; a dropped or ignored symbol goes
// straight to done, otherwise clear the new state's row, walk the suffix links
// probing transitions, copy a clone and redirect probes onto it when needed,
// then write the new state. With start_new the root row is cleared first.
// Throughput: one item at a time; the next item can be accepted in the cycle after done.
// Reset: the root row is cleared with busy high.
`default_nettype none

module suffix_automaton_builder_top #(
  parameter int MAX_LENGTH    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [sab_pkg::SYM_W-1:0] symbol,
  input  wire logic                      start_new,
  output logic                           done,
  output logic [sab_pkg::COUNT_W-1:0]    distinct_count,
  output logic                           overflow
);

  localparam int SW  = $clog2(2 * MAX_LENGTH);
  localparam int CW  = $clog2(ALPHABET_SIZE);
  localparam int SDW = 2 * SW + 1;
  localparam int TAW = SW + CW;

  logic           s_we, t_we;
  logic [SW-1:0]  s_waddr, s_raddr, t_wdata, t_rdata;
  logic [SDW-1:0] s_wdata, s_rdata;
  logic [TAW-1:0] t_waddr, t_raddr;

  sab_seq #(
    .MAX_LENGTH    (MAX_LENGTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .symbol         (symbol),
    .start_new      (start_new),
    .busy           (busy),
    .done           (done),
    .distinct_count (distinct_count),
    .overflow       (overflow),
    .s_we           (s_we),
    .s_waddr        (s_waddr),
    .s_wdata        (s_wdata),
    .s_raddr        (s_raddr),
    .s_rdata        (s_rdata),
    .t_we           (t_we),
    .t_waddr        (t_waddr),
    .t_wdata        (t_wdata),
    .t_raddr        (t_raddr),
    .t_rdata        (t_rdata)
  );

  sab_ram #(.AW(SW), .DW(SDW)) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sab_ram #(.AW(TAW), .DW(SW)) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/sab_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module sab_ram #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sab_seq.sv @@
// Construction sequencer: walks suffix links, clears and clones rows.
// Uses sab_pkg; drives the state and transition RAMs in the top level.
`default_nettype none

module sab_seq #(
  parameter int MAX_LENGTH    = 1024,
  parameter int ALPHABET_SIZE = 26,
  localparam int SW  = $clog2(2 * MAX_LENGTH),
  localparam int CW  = $clog2(ALPHABET_SIZE),
  localparam int SDW = 2 * SW + 1,
  localparam int TAW = SW + CW
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [sab_pkg::SYM_W-1:0]   symbol,
  input  wire logic                        start_new,
  output logic                             busy,
  output logic                             done,
  output logic [sab_pkg::COUNT_W-1:0]      distinct_count,
  output logic                             overflow,
  output logic                             s_we,
  output logic [SW-1:0]                    s_waddr,
  output logic [SDW-1:0]                   s_wdata,
  output logic [SW-1:0]                    s_raddr,
  input  wire logic [SDW-1:0]              s_rdata,
  output logic                             t_we,
  output logic [TAW-1:0]                   t_waddr,
  output logic [SW-1:0]                    t_wdata,
  output logic [TAW-1:0]                   t_raddr,
  input  wire logic [SW-1:0]               t_rdata
);

  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int TW = sab_pkg::COUNT_W + 1;
  localparam logic [CW-1:0] KLAST = CW'(ALPHABET_SIZE - 1);
  localparam logic [LW-1:0] MAXL = LW'(MAX_LENGTH);

  sab_pkg::seq_state_t st, st_next;

  logic [CW-1:0] k, c;
  logic          sym_ok, item, ovf;
  logic [SW-1:0] state_count, last, cur, p, q, cl;
  logic [SW-1:0] len_cur, len_p, len_q, link_cur, len_link;
  logic [LW-1:0] slen;
  logic [sab_pkg::COUNT_W-1:0] total;

  logic [SW-1:0] sp_len, sp_link, len_p1;
  logic          sp_valid, k_last;
  logic [TW-1:0] sum;

  assign sp_len   = s_rdata[SDW-1 -: SW];
  assign sp_link  = s_rdata[SW:1];
  assign sp_valid = s_rdata[0];
  assign len_p1   = len_p + SW'(1);
  assign k_last   = (k == KLAST);
  assign sum      = TW'(total) + TW'(len_cur - len_link);

  assign busy = (st != sab_pkg::ST_IDLE);
  assign done = (st == sab_pkg::ST_DONE);
  assign overflow = ovf;
  assign distinct_count = (total == sab_pkg::COUNT_MAX) ? sab_pkg::COUNT_MAX
                                                        : total + sab_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sab_pkg::ST_CLR_ROOT;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    s_we    = 1'b0;
    s_waddr = cur;
    s_wdata = '0;
    s_raddr = last;
    t_we    = 1'b0;
    t_waddr = {cur, k};
    t_wdata = '0;
    t_raddr = {p, c};
    case (st)
      sab_pkg::ST_CLR_ROOT: begin
        t_we    = 1'b1;
        t_waddr = {SW'(0), k};
        s_we    = 1'b1;
        s_waddr = '0;
        if (k_last) begin
          st_next = item ? sab_pkg::ST_DECIDE : sab_pkg::ST_IDLE;
        end
      end
      sab_pkg::ST_IDLE: begin
        if (start) begin
          st_next = start_new ? sab_pkg::ST_CLR_ROOT : sab_pkg::ST_DECIDE;
        end
      end
      sab_pkg::ST_DECIDE: begin
        if (!sym_ok || slen >= MAXL) begin
          st_next = sab_pkg::ST_DONE;
        end else begin
          st_next = sab_pkg::ST_CLR_CUR;
        end
      end
      sab_pkg::ST_CLR_CUR: begin
        t_we = 1'b1;
        if (k_last) begin
          st_next = sab_pkg::ST_W1_RD;
        end
      end
      sab_pkg::ST_W1_RD: begin
        s_raddr = p;
        st_next = sab_pkg::ST_W1_EV;
      end
      sab_pkg::ST_W1_EV: begin
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_waddr = {p, c};
          t_wdata = cur;
          if (sp_valid) begin
            t_raddr = {sp_link, c};
            s_raddr = sp_link;
          end else begin
            st_next = sab_pkg::ST_FIN;
          end
        end else begin
          s_raddr = t_rdata;
          st_next = sab_pkg::ST_Q_EV;
        end
      end
      sab_pkg::ST_Q_EV: begin
        if (sp_len == len_p1) begin
          st_next = sab_pkg::ST_FIN;
        end else begin
          s_we    = 1'b1;
          s_waddr = state_count;
          s_wdata = {len_p1, sp_link, sp_valid};
          t_raddr = {q, CW'(0)};
          st_next = sab_pkg::ST_COPY;
        end
      end
      sab_pkg::ST_COPY: begin
        t_we    = 1'b1;
        t_waddr = {cl, k};
        t_wdata = t_rdata;
        if (k_last) begin
          s_raddr = p;
          st_next = sab_pkg::ST_W2_EV;
        end else begin
          t_raddr = {q, k + CW'(1)};
        end
      end
      sab_pkg::ST_W2_EV: begin
        if (t_rdata == q) begin
          t_we    = 1'b1;
          t_waddr = {p, c};
          t_wdata = cl;
          if (sp_valid) begin
            t_raddr = {sp_link, c};
            s_raddr = sp_link;
          end else begin
            st_next = sab_pkg::ST_Q_FIX;
          end
        end else begin
          st_next = sab_pkg::ST_Q_FIX;
        end
      end
      sab_pkg::ST_Q_FIX: begin
        s_we    = 1'b1;
        s_waddr = q;
        s_wdata = {len_q, cl, 1'b1};
        st_next = sab_pkg::ST_FIN;
      end
      sab_pkg::ST_FIN: begin
        s_we    = 1'b1;
        s_waddr = cur;
        s_wdata = {len_cur, link_cur, 1'b1};
        st_next = sab_pkg::ST_DONE;
      end
      sab_pkg::ST_DONE: begin
        st_next = sab_pkg::ST_IDLE;
      end
      default: begin
        st_next = sab_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k           <= '0;
      item        <= 1'b0;
      ovf         <= 1'b0;
      state_count <= SW'(1);
      last        <= '0;
      slen        <= '0;
      total       <= '0;
    end else begin
      case (st)
        sab_pkg::ST_CLR_ROOT: begin
          k <= k_last ? '0 : k + CW'(1);
        end
        sab_pkg::ST_IDLE: begin
          if (start) begin
            c      <= CW'(symbol);
            sym_ok <= 32'(symbol) < 32'(ALPHABET_SIZE);
            item   <= 1'b1;
            k      <= '0;
            if (start_new) begin
              state_count <= SW'(1);
              last        <= '0;
              slen        <= '0;
              total       <= '0;
            end
          end
        end
        sab_pkg::ST_DECIDE: begin
          ovf <= sym_ok && (slen >= MAXL);
          cur <= state_count;
          k   <= '0;
          if (sym_ok && slen < MAXL) begin
            state_count <= state_count + SW'(1);
          end
        end
        sab_pkg::ST_CLR_CUR: begin
          if (k == '0) begin
            len_cur <= sp_len + SW'(1);
          end
          k <= k_last ? '0 : k + CW'(1);
          p <= last;
        end
        sab_pkg::ST_W1_EV: begin
          if (t_rdata == '0) begin
            if (sp_valid) begin
              p <= sp_link;
            end else begin
              link_cur <= '0;
              len_link <= '0;
            end
          end else begin
            q     <= t_rdata;
            len_p <= sp_len;
          end
        end
        sab_pkg::ST_Q_EV: begin
          len_q <= sp_len;
          k     <= '0;
          if (sp_len == len_p1) begin
            link_cur <= q;
            len_link <= sp_len;
          end else begin
            cl          <= state_count;
            state_count <= state_count + SW'(1);
          end
        end
        sab_pkg::ST_COPY: begin
          k <= k_last ? '0 : k + CW'(1);
        end
        sab_pkg::ST_W2_EV: begin
          if (t_rdata == q && sp_valid) begin
            p <= sp_link;
          end
        end
        sab_pkg::ST_Q_FIX: begin
          link_cur <= cl;
          len_link <= len_p1;
        end
        sab_pkg::ST_FIN: begin
          last  <= cur;
          slen  <= slen + LW'(1);
          total <= (sum > TW'(sab_pkg::COUNT_MAX)) ? sab_pkg::COUNT_MAX
                                                   : sum[sab_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but sequencer not busy");
  a_clone_row: assert property (@(posedge clk) disable iff (rst)
    (st == sab_pkg::ST_COPY) |-> (cl != q))
    else $error("clone copies onto its own source row");
  a_len_grow: assert property (@(posedge clk) disable iff (rst)
    (st == sab_pkg::ST_FIN) |-> (len_cur > len_link))
    else $error("new state not longer than its link");

endmodule

`default_nettype wire

@@ tb/tb_suffix_automaton_builder_top.sv @@
// Testbench for suffix_automaton_builder_top: builds strings one symbol per item
// and checks the running distinct-substring count and the overflow flag against
// a behavioral suffix automaton kept in the bench. Uses sab_pkg and the RTL.
`default_nettype none

module tb_suffix_automaton_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYM_W = sab_pkg::SYM_W;
  localparam int COUNT_W = sab_pkg::COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = sab_pkg::COUNT_MAX;
  localparam int MAXLEN = 1024;
  localparam int NSYM = 26;
  localparam int NST = 2 * MAXLEN;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sn;
  } sym_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } count_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [SYM_W-1:0] symbol = '0;
  logic start_new = 1'b0;
  logic busy, done, overflow;
  logic [COUNT_W-1:0] distinct_count;

  suffix_automaton_builder_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .symbol(symbol),
    .start_new(start_new), .done(done), .distinct_count(distinct_count),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // automaton kept by the bench
  int sa_len[NST];
  int sa_link[NST];
  bit sa_lvalid[NST];
  int sa_next[NST][NSYM];
  int sa_count, sa_last, sa_strlen;
  logic [COUNT_W-1:0] sa_total;
  int n_clones, n_ovf, n_ignored;

  sym_item_t  pending[$];
  count_res_t counts_due[$];
  sym_item_t  cur;
  bit consumed = 0;
  int gap = 0, burst = 1;
  int n_sent = 0, n_checked = 0, n_errors = 0, idle_cycles = 0;

  task automatic sa_clear_state(input int s);
    sa_len[s] = 0;
    sa_link[s] = 0;
    sa_lvalid[s] = 0;
    for (int i = 0; i < NSYM; i++) sa_next[s][i] = 0;
  endtask

  task automatic sa_clear_root();
    sa_clear_state(0);
    sa_count = 1;
    sa_last = 0;
    sa_strlen = 0;
    sa_total = '0;
  endtask

  task automatic sa_extend(input int c);
    int nw, p, q, cl, d;
    bit walking;
    nw = sa_count++;
    p = sa_last;
    walking = 1;
    sa_clear_state(nw);
    sa_len[nw] = sa_len[sa_last] + 1;
    while (walking && sa_next[p][c] == 0) begin
      sa_next[p][c] = nw;
      if (sa_lvalid[p]) p = sa_link[p];
      else walking = 0;
    end
    if (!walking) begin
      sa_link[nw] = 0;
    end else begin
      q = sa_next[p][c];
      if (sa_len[q] == sa_len[p] + 1) begin
        sa_link[nw] = q;
      end else begin
        cl = sa_count++;
        n_clones++;
        for (int i = 0; i < NSYM; i++) sa_next[cl][i] = sa_next[q][i];
        sa_len[cl] = sa_len[p] + 1;
        sa_link[cl] = sa_link[q];
        sa_lvalid[cl] = sa_lvalid[q];
        while (walking && sa_next[p][c] == q) begin
          sa_next[p][c] = cl;
          if (sa_lvalid[p]) p = sa_link[p];
          else walking = 0;
        end
        sa_link[q] = cl;
        sa_lvalid[q] = 1;
        sa_link[nw] = cl;
      end
    end
    sa_lvalid[nw] = 1;
    sa_last = nw;
    sa_strlen++;
    d = sa_len[nw] - sa_len[sa_link[nw]];
    if (int'(sa_total) + d >= int'(COUNT_MAX)) sa_total = COUNT_MAX;
    else sa_total = sa_total + COUNT_W'(d);
  endtask

  task automatic sa_add_symbol(input sym_item_t it, output count_res_t r);
    r.ovf = 1'b0;
    if (it.sn) sa_clear_root();
    if (it.sym < NSYM) begin
      if (sa_strlen >= MAXLEN) begin
        r.ovf = 1'b1;
        n_ovf++;
      end else begin
        sa_extend(int'(it.sym));
      end
    end else begin
      n_ignored++;
    end
    r.count = (sa_total >= COUNT_MAX) ? COUNT_MAX : sa_total + 1'b1;
  endtask

  task automatic push_sym(input int s, input bit sn);
    sym_item_t it;
    it.sym = SYM_W'(s);
    it.sn = sn;
    pending.insert(pending.size(), it);
  endtask

  task automatic push_word(input string w, input bit sn);
    for (int i = 0; i < w.len(); i++) push_sym(w[i] - "a", (i == 0) ? sn : 1'b0);
  endtask

  // random string; small alphabets force clones, a few symbols fall outside
  task automatic push_random_string(input int n, input bit sn);
    int alpha, s;
    alpha = ($urandom_range(0, 2) == 0) ? NSYM : $urandom_range(2, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) s = $urandom_range(0, 31);
      else s = $urandom_range(0, alpha - 1);
      push_sym(s, (i == 0) ? sn : ($urandom_range(0, 199) == 0));
    end
  endtask

  // driver: a raised start holds until the monitor sees it accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || consumed) begin
        consumed = 0;
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          symbol <= cur.sym;
          start_new <= cur.sn;
          start <= 1'b1;
          n_sent++;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: acceptance, checking and watchdog
  always @(posedge clk) begin
    count_res_t r, e;
    if (!rst) begin
      idle_cycles++;
      if (start && !busy) begin
        sa_add_symbol(cur, r);
        counts_due.insert(counts_due.size(), r);
        consumed = 1;
        idle_cycles = 0;
      end
      if (done) begin
        idle_cycles = 0;
        if (counts_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result count=%0d ovf=%0b",
                                       distinct_count, overflow);
        end else begin
          e = counts_due.pop_front();
          n_checked++;
          if (distinct_count !== e.count || overflow !== e.ovf) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d count exp %0d got %0d, overflow exp %0b got %0b",
                       n_checked, e.count, distinct_count, e.ovf, overflow);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: watchdog, no progress for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int nrand;
    n_clones = 0;
    n_ovf = 0;
    n_ignored = 0;
    for (int s = 0; s < NST; s++) sa_clear_state(s);
    sa_clear_root();

    push_sym(0, 1'b0);
    push_sym(25, 1'b0);
    push_sym(26, 1'b0);
    push_sym(31, 1'b1);
    push_sym(31, 1'b0);
    push_word("abbb", 1'b1);
    push_word("abcbc", 1'b1);
    push_word("aaaa", 1'b1);
    push_word("zz", 1'b0);
    push_sym(13, 1'b1);

    nrand = 0;
    while (nrand < 730) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      push_random_string(n, $urandom_range(0, 3) != 0);
      nrand += n;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending.size() == 0 && !start && counts_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d symbols, checked %0d results: %0d clones, %0d overflows, %0d ignored.",
             n_sent, n_checked, n_clones, n_ovf, n_ignored);
    if (n_errors == 0 && counts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
